### src/bpw_pkg.sv
// shared types and constants of the brush pixel weight block
package bpw_pkg;

	localparam int COORD_BITS    = 16;
	localparam int FRAC_BITS_DEF = 8;
	localparam int RAD_BITS      = 20;
	localparam int CTR_BITS      = 24;
	localparam int ROT_BITS      = 16;
	localparam int W_BITS        = 16;
	localparam int Q_BITS        = 16;
	localparam int ROT_FRAC      = 14;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [W_BITS-1:0] ONE_Q15   = 16'd32768;
	localparam logic [16:0]       THREE_Q15 = 17'd98304;
	localparam logic signed [ROT_BITS-1:0] COS_RESET = 16'sd16384;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SHAPE   = 3'd0,
		REG_FALLOFF = 3'd1,
		REG_CX      = 3'd2,
		REG_CY      = 3'd3,
		REG_RADIUS  = 3'd4,
		REG_COS     = 3'd5,
		REG_SIN     = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FALL_STEP   = 2'd0,
		FALL_LINEAR = 2'd1,
		FALL_SMOOTH = 2'd2
	} falloff_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pixel_x;
		logic signed [COORD_BITS-1:0] pixel_y;
	} pix_in_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic                         covered;
		logic [W_BITS-1:0]            weight;
	} pix_out_t;

endpackage

### src/brush_pixel_weight_core.sv
// brush pixel weight core: coverage and falloff weight of one pixel per request
// pipeline: 4 front stages, 21 square root stages, 1 select stage,
// 16 divider stages, 3 falloff stages
// throughput: one request per cycle; the whole pipeline holds while a result stalls
// reset: asynchronous active low; clears valid bits and loads register defaults
module brush_pixel_weight_core import bpw_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  pix_in_t                  in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output pix_out_t                 out_data,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	localparam int DW  = ((COORD_BITS+FRAC_BITS > CTR_BITS) ?
		COORD_BITS+FRAC_BITS : CTR_BITS) + 1;
	localparam int PW  = DW + ROT_BITS;
	localparam int LW  = PW + 1;
	localparam int MW  = LW - ROT_FRAC;
	localparam int SW  = 2*RAD_BITS + 1;
	localparam int RTB = RAD_BITS + 1;
	localparam int PIX_W  = 2*COORD_BITS;
	localparam int TAG1_W = PIX_W + 2 + RAD_BITS;
	localparam int TAG2_W = PIX_W + 1;

	// configuration registers
	logic                       shape_q;
	logic [1:0]                 falloff_q;
	logic signed [CTR_BITS-1:0] cx_q;
	logic signed [CTR_BITS-1:0] cy_q;
	logic [RAD_BITS-1:0]        rad_q;
	logic signed [ROT_BITS-1:0] cos_q;
	logic signed [ROT_BITS-1:0] sin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q   <= 1'b0;
			falloff_q <= FALL_STEP;
			cx_q      <= '0;
			cy_q      <= '0;
			rad_q     <= '0;
			cos_q     <= COS_RESET;
			sin_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_SHAPE:   shape_q   <= cfg_wdata[0];
				REG_FALLOFF: falloff_q <= cfg_wdata[1:0];
				REG_CX:      cx_q      <= cfg_wdata[CTR_BITS-1:0];
				REG_CY:      cy_q      <= cfg_wdata[CTR_BITS-1:0];
				REG_RADIUS:  rad_q     <= cfg_wdata[RAD_BITS-1:0];
				REG_COS:     cos_q     <= cfg_wdata[ROT_BITS-1:0];
				REG_SIN:     sin_q     <= cfg_wdata[ROT_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic     en;
	logic     out_valid_q;
	pix_out_t out_data_q;

	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// stage 1: offsets from center
	logic                 vld_s1;
	pix_in_t              pix_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= in_data;
			dx_s1  <= (DW'(in_data.pixel_x) <<< FRAC_BITS) - DW'(cx_q);
			dy_s1  <= (DW'(in_data.pixel_y) <<< FRAC_BITS) - DW'(cy_q);
		end
	end

	// stage 2: magnitudes, far test, rotation products
	logic                 vld_s2, far_s2;
	pix_in_t              pix_s2;
	logic [DW-1:0]        ax_s2, ay_s2;
	logic signed [PW-1:0] pcx_s2, psy_s2, psx_s2, pcy_s2;
	logic [DW-1:0]        ax_c, ay_c;

	assign ax_c = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
	assign ay_c = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s2 <= pix_s1;
			ax_s2  <= ax_c;
			ay_s2  <= ay_c;
			far_s2 <= (ax_c > DW'(rad_q)) || (ay_c > DW'(rad_q));
			pcx_s2 <= PW'(dx_s1) * PW'(cos_q);
			psy_s2 <= PW'(dy_s1) * PW'(sin_q);
			psx_s2 <= PW'(dx_s1) * PW'(sin_q);
			pcy_s2 <= PW'(dy_s1) * PW'(cos_q);
		end
	end

	// stage 3: squares and rotated components
	logic                      vld_s3, far_s3;
	pix_in_t                   pix_s3;
	logic [2*RAD_BITS-1:0]     sqx_s3, sqy_s3;
	logic signed [LW-1:0]      lx_s3, ly_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s3 <= pix_s2;
			far_s3 <= far_s2;
			sqx_s3 <= ax_s2[RAD_BITS-1:0] * ax_s2[RAD_BITS-1:0];
			sqy_s3 <= ay_s2[RAD_BITS-1:0] * ay_s2[RAD_BITS-1:0];
			lx_s3  <= LW'(pcx_s2) - LW'(psy_s2);
			ly_s3  <= LW'(psx_s2) + LW'(pcy_s2);
		end
	end

	// stage 4: radicand and box distance
	logic                vld_s4, far_s4, bcov_s4;
	pix_in_t             pix_s4;
	logic [SW-1:0]       rad2_s4;
	logic [RAD_BITS-1:0] bdist_s4;
	logic [LW-1:0]       mlx_c, mly_c;
	logic [MW-1:0]       mx_c, my_c, bd_c;

	assign mlx_c = lx_s3[LW-1] ? LW'(-lx_s3) : LW'(lx_s3);
	assign mly_c = ly_s3[LW-1] ? LW'(-ly_s3) : LW'(ly_s3);
	assign mx_c  = mlx_c[LW-1:ROT_FRAC];
	assign my_c  = mly_c[LW-1:ROT_FRAC];
	assign bd_c  = (mx_c > my_c) ? mx_c : my_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s4   <= pix_s3;
			far_s4   <= far_s3;
			rad2_s4  <= SW'(sqx_s3) + SW'(sqy_s3);
			bcov_s4  <= bd_c <= MW'(rad_q);
			bdist_s4 <= bd_c[RAD_BITS-1:0];
		end
	end

	// square root
	logic              sq_vld;
	logic [RTB-1:0]    sq_root;
	logic [TAG1_W-1:0] sq_tag;

	bpw_isqrt #(
		.SW    (SW),
		.RTB   (RTB),
		.TAG_W (TAG1_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_rad   (rad2_s4),
		.in_tag   ({pix_s4, far_s4, bcov_s4, bdist_s4}),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_tag  (sq_tag)
	);

	// stage 5: distance select and coverage
	logic                vld_s5, cov_s5;
	pix_in_t             pix_s5;
	logic [RAD_BITS-1:0] dist_s5;
	pix_in_t             sq_pix;
	logic                sq_far, sq_bcov;
	logic [RAD_BITS-1:0] sq_bdist;

	assign {sq_pix, sq_far, sq_bcov, sq_bdist} = sq_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s5  <= sq_pix;
			cov_s5  <= shape_q ? sq_bcov : (!sq_far && (sq_root <= RTB'(rad_q)));
			dist_s5 <= shape_q ? sq_bdist : sq_root[RAD_BITS-1:0];
		end
	end

	// normalize by radius
	logic              dv_vld;
	logic [Q_BITS-1:0] dv_quo;
	logic [TAG2_W-1:0] dv_tag;

	bpw_div #(
		.NB    (RAD_BITS),
		.QB    (Q_BITS),
		.TAG_W (TAG2_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s5),
		.in_num  (dist_s5),
		.den     (rad_q),
		.in_tag  ({pix_s5, cov_s5}),
		.out_vld (dv_vld),
		.out_quo (dv_quo),
		.out_tag (dv_tag)
	);

	// stage 6: t = 1 - n
	logic              vld_s6, cov_s6;
	pix_in_t           pix_s6;
	logic [W_BITS-1:0] t_s6;
	logic [W_BITS-1:0] n_c;

	assign n_c = (rad_q == '0) ? '0 : dv_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			{pix_s6, cov_s6} <= dv_tag;
			t_s6 <= ONE_Q15 - n_c;
		end
	end

	// stage 7: t squared and 3 - 2t
	logic              vld_s7, cov_s7;
	pix_in_t           pix_s7;
	logic [W_BITS-1:0] t_s7, u_s7;
	logic [16:0]       k_s7;
	logic [31:0]       tt_c;

	assign tt_c = t_s6 * t_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s7 <= pix_s6;
			cov_s7 <= cov_s6;
			t_s7   <= t_s6;
			u_s7   <= tt_c[30:15];
			k_s7   <= THREE_Q15 - {t_s6, 1'b0};
		end
	end

	// output stage: falloff select
	logic [32:0]       uk_c;
	logic [17:0]       sm_c;
	logic [W_BITS-1:0] w_c;

	assign uk_c = u_s7 * k_s7;
	assign sm_c = uk_c[32:15];

	always_comb begin
		case (falloff_q)
			FALL_LINEAR: w_c = t_s7;
			FALL_SMOOTH: w_c = (sm_c > 18'(ONE_Q15)) ? ONE_Q15 : sm_c[W_BITS-1:0];
			default:     w_c = ONE_Q15;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.out_x   <= pix_s7.pixel_x;
			out_data_q.out_y   <= pix_s7.pixel_y;
			out_data_q.covered <= cov_s7;
			out_data_q.weight  <= cov_s7 ? w_c : '0;
		end
	end

endmodule

### src/bpw_isqrt.sv
// pipelined integer square root, one root bit per stage, with a side tag
module bpw_isqrt import bpw_pkg::*; #(
	parameter int SW    = 2*RAD_BITS+1,
	parameter int RTB   = RAD_BITS+1,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [SW-1:0]    in_rad,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_vld,
	output logic [RTB-1:0]   out_root,
	output logic [TAG_W-1:0] out_tag
);

	localparam int TW = 2*RTB;

	logic             vld_s  [1:RTB];
	logic [SW-1:0]    rem_s  [1:RTB];
	logic [RTB-1:0]   root_s [1:RTB];
	logic [TAG_W-1:0] tag_s  [1:RTB];

	for (genvar k = 0; k < RTB; k++) begin : g_stage
		localparam int I = RTB-1-k;
		logic             cur_vld;
		logic [SW-1:0]    cur_rem;
		logic [RTB-1:0]   cur_root;
		logic [TAG_W-1:0] cur_tag;
		logic [TW-1:0]    trial;
		logic [TW-1:0]    remx;
		logic             ge;

		if (k == 0) begin : g_first
			assign cur_vld  = in_vld;
			assign cur_rem  = in_rad;
			assign cur_root = '0;
			assign cur_tag  = in_tag;
		end else begin : g_next
			assign cur_vld  = vld_s[k];
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_tag  = tag_s[k];
		end

		assign trial = (TW'(cur_root) << (I+1)) | (TW'(1) << (2*I));
		assign remx  = TW'(cur_rem);
		assign ge    = remx >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? SW'(remx - trial) : cur_rem;
				root_s[k+1] <= ge ? (cur_root | (RTB'(1) << I)) : cur_root;
				tag_s[k+1]  <= cur_tag;
			end
		end
	end

	assign out_vld  = vld_s[RTB];
	assign out_root = root_s[RTB];
	assign out_tag  = tag_s[RTB];

endmodule

### src/bpw_div.sv
// pipelined restoring divider, one quotient bit per stage, with a side tag
module bpw_div import bpw_pkg::*; #(
	parameter int NB    = RAD_BITS,
	parameter int QB    = Q_BITS,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NB-1:0]    in_num,
	input  logic [NB-1:0]    den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_vld,
	output logic [QB-1:0]    out_quo,
	output logic [TAG_W-1:0] out_tag
);

	localparam int RW = NB+QB;

	logic             vld_s [1:QB];
	logic [RW-1:0]    rem_s [1:QB];
	logic [QB-1:0]    quo_s [1:QB];
	logic [TAG_W-1:0] tag_s [1:QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int I = QB-1-k;
		logic             cur_vld;
		logic [RW-1:0]    cur_rem;
		logic [QB-1:0]    cur_quo;
		logic [TAG_W-1:0] cur_tag;
		logic [RW-1:0]    sub;
		logic             ge;

		if (k == 0) begin : g_first
			assign cur_vld = in_vld;
			assign cur_rem = RW'(in_num) << (QB-1);
			assign cur_quo = '0;
			assign cur_tag = in_tag;
		end else begin : g_next
			assign cur_vld = vld_s[k];
			assign cur_rem = rem_s[k];
			assign cur_quo = quo_s[k];
			assign cur_tag = tag_s[k];
		end

		assign sub = RW'(den) << I;
		assign ge  = cur_rem >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? (cur_rem - sub) : cur_rem;
				quo_s[k+1] <= ge ? (cur_quo | (QB'(1) << I)) : cur_quo;
				tag_s[k+1] <= cur_tag;
			end
		end
	end

	assign out_vld = vld_s[QB];
	assign out_quo = quo_s[QB];
	assign out_tag = tag_s[QB];

endmodule
